// ===== sv/i2da_pkg.sv =====
// Shared constants and control types for the integer to decimal text converter.
`timescale 1ns / 1ps
`default_nettype none

package i2da_pkg;

  // Width of the incoming integer field and of one emitted character.
  localparam int NUMBER_WIDTH = 64;
  localparam int CHAR_WIDTH   = 6;

  // ASCII codes, already cut to the character width.
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new number and clear the digit register
    logic step;        // one shift-add-3 conversion step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // load a minus sign into the output register
    logic emit_digit;  // load the top digit into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;         // captured number is negative
    logic bits_done;   // last conversion step is under way
    logic top_zero;    // top digit of the digit register is zero
    logic one_left;    // exactly one digit remains to be sent
    logic out_free;    // output register can take a character this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== sv/int64_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII text converter.
// Input stream: one transfer carries a two's complement integer in s_axis_tdata;
// only its low VALUE_WIDTH bits count, bit VALUE_WIDTH-1 being the sign.
// Output stream: one transfer per character, most significant first: an optional
// '-' and then the decimal digits without leading zeros; tlast marks the final digit.
// Steps per number: capture, the sign decision (the minus sign goes out then),
// VALUE_WIDTH shift-add-3 conversion steps, one step per leading zero digit
// dropped, one step to leave the zero skip, and one step per digit sent; the
// conversion runs at one bit per cycle in the BCD converter.
// Numbers are handled one at a time; s_axis_tready rises as the last digit enters
// the output register, so the next number can be taken while that digit waits.
// A receiver stall holds the character in the output register and pauses the
// controller before the next character; nothing is lost or repeated.
// Reset clears the controller to idle with s_axis_tready high and empties the
// output register.
`timescale 1ns / 1ps
`default_nettype none

module int64_to_decimal_ascii
  import i2da_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [NUMBER_WIDTH-1:0] s_axis_tdata,  // [63:0] number
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [5:0] ascii_char, [7:6] zero
  output logic                         m_axis_tlast   // is_last
);

  cmd_t                  cmd;
  status_t               status;
  logic [CHAR_WIDTH-1:0] out_char;

  // Control sequencer.
  i2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Conversion datapath and output register.
  i2da_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_char};

`ifndef NO_ASSERTIONS
  // Only one number is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a number was still in work");

  // Ready returns only once the final digit sits in the output register.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> (m_axis_tvalid && m_axis_tlast))
    else $error("ready rose without a final digit pending");

  // A minus sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[5:0] == CHAR_MINUS)) |-> !m_axis_tlast)
    else $error("minus sign flagged as last character");
`endif

endmodule

`default_nettype wire

// ===== sv/i2da_dp.sv =====
// Datapath: magnitude capture, shift-add-3 binary to BCD conversion, output register.
`timescale 1ns / 1ps
`default_nettype none

module i2da_dp
  import i2da_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [NUMBER_WIDTH-1:0] number_i,
  input  wire cmd_t                    cmd_i,
  output status_t                      status_o,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [CHAR_WIDTH-1:0]        out_char_o,
  output logic                         out_last_o
);

  // Enough decimal digits for a magnitude of up to 2**(VALUE_WIDTH-1).
  localparam int DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = $clog2(VALUE_WIDTH);
  localparam int DIG_W  = $clog2(DIGITS + 1);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DIG_W-1:0]       dig_q, dig_d;
  logic                   neg_q, neg_d;
  logic [3:0]             top_digit;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_WIDTH-1:0]  out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;
  logic                   out_free;

  // Magnitude of the low VALUE_WIDTH bits; the most negative value maps to 2**(W-1).
  assign raw    = number_i[VALUE_WIDTH-1:0];
  assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3) : bcd_q[4*i +: 4];
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign out_free  = !out_valid_q || out_ready_i;

  // Next state of the conversion registers.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    dig_d = dig_q;
    neg_d = neg_q;
    if (cmd_i.load) begin
      bin_d = mag_in;
      bcd_d = '0;
      cnt_d = CNT_W'(VALUE_WIDTH - 1);
      dig_d = DIG_W'(DIGITS);
      neg_d = raw[VALUE_WIDTH-1];
    end else if (cmd_i.step) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
    end else if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_d = {bcd_q[BCD_W-5:0], 4'b0000};
      dig_d = dig_q - DIG_W'(1);
    end
  end

  // Output register: one character waits here until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      out_char_d  = CHAR_MINUS;
      out_last_d  = 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      out_char_d  = CHAR_ZERO + {2'b00, top_digit};
      out_last_d  = (dig_q == DIG_W'(1));
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    cnt_q      <= cnt_d;
    dig_q      <= dig_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.neg       = neg_q;
  assign status_o.bits_done = (cnt_q == '0);
  assign status_o.top_zero  = (top_digit == 4'd0);
  assign status_o.one_left  = (dig_q == DIG_W'(1));
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== sv/i2da_ctrl.sv =====
// Controller: sequences capture, sign, conversion, leading-zero skip and digit output.
`timescale 1ns / 1ps
`default_nettype none

module i2da_ctrl
  import i2da_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  // Commands and next state.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ready_d = ready_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          ready_d    = 1'b0;
          state_d    = S_SIGN;
        end
      end
      S_SIGN: begin
        if (!status_i.neg) begin
          state_d = S_CONV;
        end else if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.bits_done) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.one_left) begin
            ready_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

// ===== tb/int64_to_decimal_ascii_checker.sv =====
// Scoreboard for the integer to decimal text converter: predicts and checks the character stream.
`timescale 1ns / 1ps

module int64_to_decimal_ascii_checker
  import i2da_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [NUMBER_WIDTH-1:0] s_axis_tdata,   // [63:0] number
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [7:0]              m_axis_tdata,   // [5:0] ascii_char, [7:6] zero
  input  logic                    m_axis_tlast,   // is_last
  output int                      errors_o,
  output int                      pending_o,
  output int                      chars_o
);

  // Longest text the converter can produce: a sign and nineteen digits.
  localparam int DIGITS_MAX = 19;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ascii_char;
    logic                  is_last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches = 0;
  int         chars_seen = 0;

  // Expands one number into its expected characters and appends them to the queue.
  function automatic void queue_decimal_text(input logic [NUMBER_WIDTH-1:0] number);
    logic [63:0]           width_mask;
    logic [63:0]           raw;
    logic [63:0]           magnitude;
    logic                  negative;
    logic [CHAR_WIDTH-1:0] digits[$];
    text_char_t            entry;
    width_mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
    raw        = number & width_mask;
    negative   = raw[VALUE_WIDTH-1];
    // The magnitude is taken in unsigned arithmetic so the most negative value survives.
    magnitude  = negative ? ((64'd0 - raw) & width_mask) : raw;
    do begin
      digits.push_front(CHAR_ZERO + CHAR_WIDTH'(magnitude % 64'd10));
      magnitude = magnitude / 64'd10;
    end while (magnitude != 0 && digits.size() < DIGITS_MAX);
    if (negative) begin
      entry.ascii_char = CHAR_MINUS;
      entry.is_last    = 1'b0;
      expected_text.push_back(entry);
    end
    foreach (digits[i]) begin
      entry.ascii_char = digits[i];
      entry.is_last    = (i == digits.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  // Results are checked before new numbers are queued, since a character never
  // belongs to the number accepted at the same edge.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        chars_seen = chars_seen + 1;
        if (expected_text.size() == 0) begin
          $error("unexpected character transfer: ascii_char %0d is_last %0b",
                 m_axis_tdata[5:0], m_axis_tlast);
          mismatches = mismatches + 1;
        end else begin
          want = expected_text.pop_front();
          if (m_axis_tdata[5:0] !== want.ascii_char) begin
            $error("ascii_char mismatch: expected %0d, actual %0d",
                   want.ascii_char, m_axis_tdata[5:0]);
            mismatches = mismatches + 1;
          end
          if (m_axis_tlast !== want.is_last) begin
            $error("is_last mismatch: expected %0b, actual %0b", want.is_last, m_axis_tlast);
            mismatches = mismatches + 1;
          end
          if (m_axis_tdata[7:6] !== 2'b00) begin
            $error("tdata padding mismatch: expected 0, actual %0d", m_axis_tdata[7:6]);
            mismatches = mismatches + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        queue_decimal_text(s_axis_tdata);
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_text.size();
    chars_o   <= chars_seen;
  end

endmodule

// ===== tb/tb_int64_to_decimal_ascii.sv =====
// Testbench top for the integer to decimal text converter: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_int64_to_decimal_ascii;
  import i2da_pkg::*;

  localparam int  RANDOM_NUMBERS = 460;
  localparam int  IDLE_PERCENT   = 24;
  localparam int  DRAIN_CYCLES   = 120;
  localparam int  CYCLE_LIMIT    = 600000;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [NUMBER_WIDTH-1:0] s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;
  logic                    m_axis_tlast;

  int   errors;
  int   pending;
  int   chars_seen;
  int   numbers_sent   = 0;
  int   negatives_sent = 0;
  int   cycle_count    = 0;
  logic steady         = 1'b0;

  always #4 clk_i = ~clk_i;

  int64_to_decimal_ascii dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  int64_to_decimal_ascii_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors_o      (errors),
    .pending_o     (pending),
    .chars_o       (chars_seen)
  );

  // Receiver stalls at random, except during the steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** int64_to_decimal_ascii: FAILED **");
      $finish;
    end
  end

  // Offers one number, with random idle cycles ahead of it, and waits for its transfer.
  task automatic send_number(input logic [NUMBER_WIDTH-1:0] number);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= number;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    numbers_sent = numbers_sent + 1;
    if (number[NUMBER_WIDTH-1]) negatives_sent = negatives_sent + 1;
  endtask

  // Waits until every queued character has been seen.
  task automatic wait_for_text;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Draws a value with a random magnitude, so that all text lengths occur.
  function automatic logic [NUMBER_WIDTH-1:0] random_number;
    logic [NUMBER_WIDTH-1:0] value;
    value = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       random_number = value;
      1:       random_number = NUMBER_WIDTH'($urandom_range(999));
      default: random_number = value >> $urandom_range(NUMBER_WIDTH - 1);
    endcase
    if ($urandom_range(1)) random_number = -random_number;
  endfunction

  initial begin
    logic [NUMBER_WIDTH-1:0] directed_numbers[$];
    directed_numbers = '{
      64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100, -64'sd101,
      64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'h7fff_ffff_ffff_fffe, 64'd1000000000000000000, 64'd999999999999999999,
      -64'sd1000000000000000000, 64'd1234567890123456789, -64'sd9876543210,
      64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa,
      64'h5555_5555_5555_5555
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed values: zero, one-digit and carry boundaries, both extremes.
    foreach (directed_numbers[i]) send_number(directed_numbers[i]);

    // Let the converter drain completely before the random part.
    wait_for_text();

    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      steady = (n >= 200 && n < 280);
      send_number(random_number());
      if (n == 120) wait_for_text();
    end
    steady = 1'b0;

    wait_for_text();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative) into %0d checked characters.",
             numbers_sent, negatives_sent, chars_seen);
    if (errors == 0 && pending == 0) begin
      $display("** int64_to_decimal_ascii: PASSED **");
    end else begin
      $display("** int64_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

endmodule
